[rtl/bbsc_pkg.sv]
// ----------------------------------------------------------------------------
// bbsc_pkg
// Shared types, constants and saturating helpers for the box-box contact test.
// ----------------------------------------------------------------------------
package bbsc_pkg;

  localparam int AXES_PER_BOX_DEF = 2;
  localparam int FRAC_BITS_DEF    = 16;

  // vector store layout: box * BOX_STRIDE + vector
  localparam int VEC_WORDS  = 10;
  localparam logic [3:0] BOX_STRIDE = 4'd5;
  localparam logic [2:0] VEC_POS    = 3'd3;
  localparam logic [2:0] VEC_HALF   = 3'd4;
  localparam logic [2:0] VEC_COUNT  = 3'd5;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

  typedef logic [2:0][31:0] vec_t;

  typedef struct packed {
    logic              box_select;
    logic [2:0]        vector_select;
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
    logic              last;
  } bbsc_req_t;

  typedef struct packed {
    logic              hit;
    logic [1:0]        axis_case;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic [30:0]       depth;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } bbsc_res_t;

  typedef enum logic [2:0] {
    LD_NONE, LD_X, LD_Y, LD_AX, LD_H
  } ld_sel_t;

  typedef enum logic [2:0] {
    MS_TAX, MS_AXY, MS_HT, MS_NDIR, MS_YH
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_TOC, OP_DIST, OP_TVAL, OP_RSUB, OP_EVAL,
    OP_NFLIP, OP_VFLIP, OP_HIT, OP_MISS
  } dp_op_t;

  typedef struct packed {
    logic       wr_en;
    logic [3:0] wr_addr;
    logic       rd_en;
    logic [3:0] rd_addr;
    ld_sel_t    ld_sel;
    logic       mul_en;
    mul_sel_t   mul_sel;
    logic [1:0] ka;
    logic [1:0] kb;
    logic       acc_clr;
    logic       rad_clr;
    logic       p_clr;
    dp_op_t     op;
    logic       eb;
    logic [1:0] ei;
  } dp_cmd_t;

  typedef struct packed {
    logic       pen_pos;
    logic       win_b;
    logic [1:0] win_i;
  } dp_stat_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_P_RDA, ST_P_RDB, ST_P_LDB, ST_P_TOC,
    ST_AX_RD, ST_AX_LD, ST_D_MUL, ST_D_WAIT, ST_D_FIN,
    ST_H_RD, ST_H_LD, ST_C_RD, ST_C_LD, ST_C_MUL, ST_C_WAIT, ST_C_TV,
    ST_C_HMUL, ST_C_HWAIT, ST_R_SUB, ST_EVAL,
    ST_W_RD, ST_W_LD, ST_N_MUL, ST_N_WAIT, ST_N_FLIP,
    ST_V_RD, ST_V_LD, ST_K_RD, ST_K_LD, ST_K_MUL, ST_K_WAIT, ST_K_FLIP,
    ST_K_PMUL, ST_K_PWAIT, ST_O_RD, ST_O_LD, ST_OUT_HIT, ST_OUT_MISS
  } bbsc_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > WIDE_MAX) r = Q_MAX;
    else if (v < WIDE_MIN) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] abs_sat(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == Q_MIN) r = Q_MAX;
    else if (v < 0) r = -v;
    else r = v;
    return r;
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == Q_MIN) r = Q_MAX;
    else r = -v;
    return r;
  endfunction

  function automatic logic [3:0] vaddr(input logic b, input logic [2:0] v);
    logic [3:0] r;
    r = (b ? BOX_STRIDE : 4'd0) + {1'b0, v};
    return r;
  endfunction

endpackage

[rtl/bbsc_dp.sv]
// ----------------------------------------------------------------------------
// bbsc_dp
// Datapath: vector store, shared 32x32 multiplier, accumulators, result reg.
// ----------------------------------------------------------------------------
module bbsc_dp import bbsc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  bbsc_req_t request,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      done,
  output bbsc_res_t result
);

  vec_t mem [VEC_WORDS];
  vec_t rdata;
  vec_t x, y, t, u, ax, h, dir;
  logic signed [31:0] tval, best;
  logic signed [63:0] acc, rad, pen, prod, full;
  logic signed [63:0] p [3];
  logic               pv;
  mul_sel_t           psel;
  logic [1:0]         pk;
  logic               win_b;
  logic [1:0]         win_i;
  logic signed [31:0] opa, opb;
  logic signed [31:0] acc_s, pen_s;
  logic signed [31:0] best_abs;

  assign acc_s    = sat32(acc);
  assign pen_s    = sat32(pen);
  assign best_abs = abs_sat(best);
  assign dir      = win_b ? u : t;

  assign stat.pen_pos = pen_s > 0;
  assign stat.win_b   = win_b;
  assign stat.win_i   = win_i;

  // vector store, one vector per write, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[cmd.wr_addr] <= {request.comp_z, request.comp_y, request.comp_x};
    if (cmd.rd_en) rdata <= mem[cmd.rd_addr];
  end

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MS_TAX:  begin opa = $signed(t[cmd.ka]);  opb = $signed(ax[cmd.ka]);  end
      MS_AXY:  begin opa = $signed(ax[cmd.ka]); opb = $signed(y[cmd.ka]);   end
      MS_HT:   begin opa = $signed(h[cmd.ka]);  opb = tval;                 end
      MS_NDIR: begin opa = $signed(ax[cmd.ka]); opb = $signed(dir[cmd.ka]); end
      MS_YH:   begin opa = $signed(y[cmd.ka]);  opb = $signed(h[cmd.kb]);   end
      default: begin opa = '0;                  opb = '0;                   end
    endcase
  end

  assign full = opa * opb;

  // product stage, floor shift
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= cmd.mul_en;
    end
    prod <= full >>> FRAC_BITS;
    psel <= cmd.mul_sel;
    pk   <= cmd.ka;
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) acc <= '0;
    else if (pv && (psel == MS_TAX || psel == MS_AXY || psel == MS_NDIR)) acc <= acc + prod;
    if (cmd.rad_clr) rad <= '0;
    else if (pv && psel == MS_HT) rad <= rad + prod;
    for (int j = 0; j < 3; j++) begin
      if (cmd.p_clr) p[j] <= '0;
      else if (pv && psel == MS_YH && pk == 2'(j)) p[j] <= p[j] + prod;
    end
  end

  // vector loads and scalar steps
  always_ff @(posedge clk) begin
    if (rst) begin
      best  <= Q_MIN;
      win_b <= 1'b0;
      win_i <= '0;
    end else begin
      case (cmd.op)
        OP_TOC: begin
          best  <= Q_MIN;
          win_b <= 1'b0;
          win_i <= '0;
        end
        OP_EVAL: begin
          if (pen_s > best) begin
            best  <= pen_s;
            win_b <= cmd.eb;
            win_i <= cmd.ei;
          end
        end
        default: ;
      endcase
    end

    case (cmd.ld_sel)
      LD_X:    x  <= rdata;
      LD_Y:    y  <= rdata;
      LD_AX:   ax <= rdata;
      LD_H:    h  <= rdata;
      default: ;
    endcase

    case (cmd.op)
      OP_TOC: begin
        for (int j = 0; j < 3; j++) begin
          t[j] <= sat32(64'($signed(y[j])) - 64'($signed(x[j])));
          u[j] <= sat32(64'($signed(x[j])) - 64'($signed(y[j])));
        end
      end
      OP_DIST: pen  <= 64'(abs_sat(acc_s));
      OP_TVAL: tval <= abs_sat(acc_s);
      OP_RSUB: pen  <= pen - 64'(sat32(rad));
      OP_NFLIP: begin
        if (acc_s > 0)
          for (int j = 0; j < 3; j++) ax[j] <= neg_sat($signed(ax[j]));
      end
      OP_VFLIP: begin
        if (acc_s < 0) h[cmd.kb] <= neg_sat($signed(h[cmd.kb]));
      end
      default: ;
    endcase
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.op == OP_HIT) || (cmd.op == OP_MISS);
    end
    if (cmd.op == OP_HIT) begin
      result.hit       <= 1'b1;
      result.axis_case <= 2'({win_b, 1'b0} + {1'b0, win_i});
      result.normal_x  <= $signed(ax[0]);
      result.normal_y  <= $signed(ax[1]);
      result.normal_z  <= $signed(ax[2]);
      result.depth     <= best_abs[30:0];
      result.point_x   <= sat32(p[0] + 64'($signed(x[0])));
      result.point_y   <= sat32(p[1] + 64'($signed(x[1])));
      result.point_z   <= sat32(p[2] + 64'($signed(x[2])));
    end else if (cmd.op == OP_MISS) begin
      result <= '0;
    end
  end

endmodule

[rtl/bbsc_ctrl.sv]
// ----------------------------------------------------------------------------
// bbsc_ctrl
// Controller: request accept, vector writes and the test sequence.
// ----------------------------------------------------------------------------
module bbsc_ctrl import bbsc_pkg::*; #(
  parameter int AXES_PER_BOX = AXES_PER_BOX_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  bbsc_req_t request,
  input  dp_stat_t  stat,
  output logic      busy,
  output dp_cmd_t   cmd
);

  localparam int NAX = 2 * AXES_PER_BOX;
  localparam int NW  = $clog2(NAX);

  bbsc_state_t state, state_next;
  logic [NW-1:0] n, n_next;
  logic          c, c_next;
  logic [1:0]    k, k_next, j, j_next;
  logic          cur_b, other;
  logic [1:0]    cur_i;

  assign cur_b = n[0];
  assign cur_i = 2'(n >> 1);
  assign other = ~stat.win_b;
  assign busy  = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n <= '0;
      c <= 1'b0;
      k <= '0;
      j <= '0;
    end else begin
      state <= state_next;
      n <= n_next;
      c <= c_next;
      k <= k_next;
      j <= j_next;
    end
  end

  // next state and loop counters
  always_comb begin
    state_next = state;
    n_next = n;
    c_next = c;
    k_next = k;
    j_next = j;
    case (state)
      ST_IDLE:   if (start && request.last) state_next = ST_P_RDA;
      ST_P_RDA:  state_next = ST_P_RDB;
      ST_P_RDB:  state_next = ST_P_LDB;
      ST_P_LDB:  state_next = ST_P_TOC;
      ST_P_TOC:  begin n_next = '0; state_next = ST_AX_RD; end
      ST_AX_RD:  state_next = ST_AX_LD;
      ST_AX_LD:  begin j_next = '0; state_next = ST_D_MUL; end
      ST_D_MUL:  begin
        j_next = j + 2'd1;
        if (j == 2'd2) state_next = ST_D_WAIT;
      end
      ST_D_WAIT: state_next = ST_D_FIN;
      ST_D_FIN:  begin c_next = 1'b0; state_next = ST_H_RD; end
      ST_H_RD:   state_next = ST_H_LD;
      ST_H_LD:   begin k_next = '0; state_next = ST_C_RD; end
      ST_C_RD:   state_next = ST_C_LD;
      ST_C_LD:   begin j_next = '0; state_next = ST_C_MUL; end
      ST_C_MUL:  begin
        j_next = j + 2'd1;
        if (j == 2'd2) state_next = ST_C_WAIT;
      end
      ST_C_WAIT: state_next = ST_C_TV;
      ST_C_TV:   state_next = ST_C_HMUL;
      ST_C_HMUL: state_next = ST_C_HWAIT;
      ST_C_HWAIT: begin
        if (k == 2'd2) state_next = ST_R_SUB;
        else begin k_next = k + 2'd1; state_next = ST_C_RD; end
      end
      ST_R_SUB:  begin
        if (c) state_next = ST_EVAL;
        else begin c_next = 1'b1; state_next = ST_H_RD; end
      end
      ST_EVAL:   begin
        if (stat.pen_pos) state_next = ST_OUT_MISS;
        else if (n == NW'(NAX - 1)) state_next = ST_W_RD;
        else begin n_next = n + NW'(1); state_next = ST_AX_RD; end
      end
      ST_W_RD:   state_next = ST_W_LD;
      ST_W_LD:   begin j_next = '0; state_next = ST_N_MUL; end
      ST_N_MUL:  begin
        j_next = j + 2'd1;
        if (j == 2'd2) state_next = ST_N_WAIT;
      end
      ST_N_WAIT: state_next = ST_N_FLIP;
      ST_N_FLIP: state_next = ST_V_RD;
      ST_V_RD:   state_next = ST_V_LD;
      ST_V_LD:   begin k_next = '0; state_next = ST_K_RD; end
      ST_K_RD:   state_next = ST_K_LD;
      ST_K_LD:   begin j_next = '0; state_next = ST_K_MUL; end
      ST_K_MUL:  begin
        j_next = j + 2'd1;
        if (j == 2'd2) state_next = ST_K_WAIT;
      end
      ST_K_WAIT: state_next = ST_K_FLIP;
      ST_K_FLIP: begin j_next = '0; state_next = ST_K_PMUL; end
      ST_K_PMUL: begin
        j_next = j + 2'd1;
        if (j == 2'd2) state_next = ST_K_PWAIT;
      end
      ST_K_PWAIT: begin
        if (k == 2'd2) state_next = ST_O_RD;
        else begin k_next = k + 2'd1; state_next = ST_K_RD; end
      end
      ST_O_RD:   state_next = ST_O_LD;
      ST_O_LD:   state_next = ST_OUT_HIT;
      ST_OUT_HIT:  state_next = ST_IDLE;
      ST_OUT_MISS: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    cmd.ld_sel  = LD_NONE;
    cmd.mul_sel = MS_TAX;
    cmd.op      = OP_NONE;
    cmd.ka      = j;
    cmd.kb      = k;
    cmd.eb      = cur_b;
    cmd.ei      = cur_i;
    cmd.wr_addr = vaddr(request.box_select, request.vector_select);
    case (state)
      ST_IDLE:   cmd.wr_en = start && (request.vector_select < VEC_COUNT);
      ST_P_RDA:  begin cmd.rd_en = 1'b1; cmd.rd_addr = vaddr(1'b0, VEC_POS); end
      ST_P_RDB:  begin
        cmd.ld_sel = LD_X;
        cmd.rd_en = 1'b1;
        cmd.rd_addr = vaddr(1'b1, VEC_POS);
      end
      ST_P_LDB:  cmd.ld_sel = LD_Y;
      ST_P_TOC:  cmd.op = OP_TOC;
      ST_AX_RD:  begin cmd.rd_en = 1'b1; cmd.rd_addr = vaddr(cur_b, {1'b0, cur_i}); end
      ST_AX_LD:  cmd.ld_sel = LD_AX;
      ST_D_MUL:  begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_TAX;
        cmd.acc_clr = (j == 2'd0);
      end
      ST_D_FIN:  cmd.op = OP_DIST;
      ST_H_RD:   begin cmd.rd_en = 1'b1; cmd.rd_addr = vaddr(c, VEC_HALF); end
      ST_H_LD:   begin cmd.ld_sel = LD_H; cmd.rad_clr = 1'b1; end
      ST_C_RD:   begin cmd.rd_en = 1'b1; cmd.rd_addr = vaddr(c, {1'b0, k}); end
      ST_C_LD:   cmd.ld_sel = LD_Y;
      ST_C_MUL:  begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_AXY;
        cmd.acc_clr = (j == 2'd0);
      end
      ST_C_TV:   cmd.op = OP_TVAL;
      ST_C_HMUL: begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_HT; cmd.ka = k; end
      ST_R_SUB:  cmd.op = OP_RSUB;
      ST_EVAL:   cmd.op = OP_EVAL;
      ST_W_RD:   begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = vaddr(stat.win_b, {1'b0, stat.win_i});
      end
      ST_W_LD:   cmd.ld_sel = LD_AX;
      ST_N_MUL:  begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_NDIR;
        cmd.acc_clr = (j == 2'd0);
      end
      ST_N_FLIP: begin cmd.op = OP_NFLIP; cmd.p_clr = 1'b1; end
      ST_V_RD:   begin cmd.rd_en = 1'b1; cmd.rd_addr = vaddr(other, VEC_HALF); end
      ST_V_LD:   cmd.ld_sel = LD_H;
      ST_K_RD:   begin cmd.rd_en = 1'b1; cmd.rd_addr = vaddr(other, {1'b0, k}); end
      ST_K_LD:   cmd.ld_sel = LD_Y;
      ST_K_MUL:  begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_AXY;
        cmd.acc_clr = (j == 2'd0);
      end
      ST_K_FLIP: cmd.op = OP_VFLIP;
      ST_K_PMUL: begin cmd.mul_en = 1'b1; cmd.mul_sel = MS_YH; end
      ST_O_RD:   begin cmd.rd_en = 1'b1; cmd.rd_addr = vaddr(other, VEC_POS); end
      ST_O_LD:   cmd.ld_sel = LD_X;
      ST_OUT_HIT:  cmd.op = OP_HIT;
      ST_OUT_MISS: cmd.op = OP_MISS;
      default: ;
    endcase
  end

endmodule

[rtl/box_box_sat_contact.sv]
// ----------------------------------------------------------------------------
// box_box_sat_contact
// Separating-axis contact test between two oriented boxes, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. Each
//   request with vector_select below 5 stores one 3-vector of a box (axis
//   column, position or half sizes); requests can follow back to back while
//   busy is low. A request with last set stores its vector, if any, and then
//   runs the test; busy stays high until the result is out.
//   The test runs on one shared 32x32 multiplier, one product per cycle,
//   sequenced by the controller: a setup step, then one pass per tested
//   axis, then the normal and contact point. A miss ends right after the
//   first separating axis, so it is shorter.
//   The result appears on result for exactly one cycle with done high; the
//   receiver cannot stall it, and busy drops in the same cycle done rises.
//   Reset clears the controller and the strobe; the vector store holds
//   whatever was there until written again.
// ----------------------------------------------------------------------------
module box_box_sat_contact import bbsc_pkg::*; #(
  parameter int AXES_PER_BOX = AXES_PER_BOX_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  bbsc_req_t request,
  output logic      done,
  output bbsc_res_t result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bbsc_ctrl #(.AXES_PER_BOX(AXES_PER_BOX)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  bbsc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

[tb/box_box_sat_contact_test.sv]
// ----------------------------------------------------------------------------
// box_box_sat_contact_test
// Loads box pairs vector by vector, mostly complete pairs with random
// content, and checks each contact result against an in-bench predictor.
// ----------------------------------------------------------------------------
module box_box_sat_contact_test;
  import bbsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int AXES = 2;
  localparam int FB = 16;
  localparam int CYCLE_LIMIT = 900000;

  // Box store and contact predictor
  class contact_board;
    logic signed [31:0] store [2][5][3];
    bbsc_res_t pending[$];
    int errors;

    function new();
      errors = 0;
      foreach (store[b, v, c]) store[b][v][c] = '0;
    endfunction

    function logic signed [63:0] mulq(logic signed [31:0] a, logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return p >>> FB;
    endfunction

    function logic signed [31:0] clip(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function logic signed [31:0] mag(logic signed [31:0] v);
      if (v == 32'sh80000000) return 32'sh7fffffff;
      return v < 0 ? -v : v;
    endfunction

    function logic signed [31:0] flip(logic signed [31:0] v);
      if (v == 32'sh80000000) return 32'sh7fffffff;
      return -v;
    endfunction

    function logic signed [31:0] dot(logic signed [31:0] a[3], logic signed [31:0] b[3]);
      return clip(mulq(a[0], b[0]) + mulq(a[1], b[1]) + mulq(a[2], b[2]));
    endfunction

    function logic signed [31:0] extent(int bx, logic signed [31:0] ax[3]);
      logic signed [63:0] s;
      s = '0;
      for (int k = 0; k < 3; k++) s += mulq(store[bx][4][k], mag(dot(ax, store[bx][k])));
      return clip(s);
    endfunction

    // note an accepted request; queues a contact prediction on last
    function void note_request(bbsc_req_t r);
      logic signed [31:0] toc[3], dir[3], nrm[3], vert[3], ax[3];
      logic signed [31:0] pen, best;
      logic signed [63:0] s;
      bbsc_res_t e;
      int wb, wi;
      if (r.vector_select < 5) begin
        store[r.box_select][r.vector_select][0] = r.comp_x;
        store[r.box_select][r.vector_select][1] = r.comp_y;
        store[r.box_select][r.vector_select][2] = r.comp_z;
      end
      if (!r.last) return;
      e = '0;
      for (int j = 0; j < 3; j++) toc[j] = clip(64'(store[1][3][j]) - 64'(store[0][3][j]));
      best = 32'sh80000000;
      wb = 0;
      wi = 0;
      for (int i = 0; i < AXES; i++) begin
        for (int b = 0; b < 2; b++) begin
          ax = store[b][i];
          pen = clip(64'(mag(dot(toc, ax))) - 64'(extent(0, ax)) - 64'(extent(1, ax)));
          if (pen > 0) begin
            pending.push_back(e);
            return;
          end
          if (pen > best) begin
            best = pen;
            wb = b;
            wi = i;
          end
        end
      end
      for (int j = 0; j < 3; j++)
        dir[j] = wb ? clip(64'(store[0][3][j]) - 64'(store[1][3][j])) : toc[j];
      nrm = store[wb][wi];
      if (dot(nrm, dir) > 0) for (int j = 0; j < 3; j++) nrm[j] = flip(nrm[j]);
      vert = store[1-wb][4];
      for (int k = 0; k < 3; k++)
        if (dot(store[1-wb][k], nrm) < 0) vert[k] = flip(vert[k]);
      e.hit = 1'b1;
      e.axis_case = 2'(wb * 2 + wi);
      e.normal_x = nrm[0];
      e.normal_y = nrm[1];
      e.normal_z = nrm[2];
      e.depth = 31'(mag(best));
      for (int j = 0; j < 3; j++) begin
        s = 64'(store[1-wb][3][j]);
        for (int k = 0; k < 3; k++) s += mulq(store[1-wb][k][j], vert[k]);
        if (j == 0) e.point_x = clip(s);
        else if (j == 1) e.point_y = clip(s);
        else e.point_z = clip(s);
      end
      pending.push_back(e);
    endfunction

    function void check_result(bbsc_res_t a);
      bbsc_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected contact result");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.hit !== e.hit) begin $error("hit exp %0d got %0d", e.hit, a.hit); errors++; end
      if (a.axis_case !== e.axis_case) begin
        $error("axis_case exp %0d got %0d", e.axis_case, a.axis_case); errors++;
      end
      if (a.normal_x !== e.normal_x) begin
        $error("normal_x exp %0d got %0d", e.normal_x, a.normal_x); errors++;
      end
      if (a.normal_y !== e.normal_y) begin
        $error("normal_y exp %0d got %0d", e.normal_y, a.normal_y); errors++;
      end
      if (a.normal_z !== e.normal_z) begin
        $error("normal_z exp %0d got %0d", e.normal_z, a.normal_z); errors++;
      end
      if (a.depth !== e.depth) begin $error("depth exp %0d got %0d", e.depth, a.depth); errors++; end
      if (a.point_x !== e.point_x) begin
        $error("point_x exp %0d got %0d", e.point_x, a.point_x); errors++;
      end
      if (a.point_y !== e.point_y) begin
        $error("point_y exp %0d got %0d", e.point_y, a.point_y); errors++;
      end
      if (a.point_z !== e.point_z) begin
        $error("point_z exp %0d got %0d", e.point_z, a.point_z); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  bbsc_req_t request = '0;
  bbsc_res_t result;
  contact_board board = new();
  int cycles = 0;
  bit quiet = 1'b0;

  box_box_sat_contact dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("box_box_sat_contact_test: done, errors");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  // send one request, with a random gap first unless quiet; start stays high afterwards
  task automatic send(input bbsc_req_t r);
    while (!quiet && $urandom_range(99) < 15) begin
      start <= 1'b0;
      @(posedge clk);
    end
    request <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(r);
  endtask

  function automatic logic signed [31:0] rand_comp(input int mode);
    case (mode)
      0: return $urandom();
      1: return $signed(32'($urandom_range(0, 1 << 17))) - (1 <<< 16);
      2: return $signed(32'($urandom_range(0, 8 << 16))) - (4 <<< 16);
      default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  task automatic send_vec(input bit bx, input logic [2:0] vs, input int mode, input bit lst);
    bbsc_req_t r;
    r.box_select = bx;
    r.vector_select = vs;
    r.comp_x = rand_comp(mode);
    r.comp_y = rand_comp(mode);
    r.comp_z = rand_comp(mode);
    r.last = lst;
    send(r);
  endtask

  // full pair; in mode 1 rotation-ish axes, nearby positions, modest halves
  task automatic send_pair(input int mode);
    int m;
    for (int b = 0; b < 2; b++)
      for (int v = 0; v < 5; v++) begin
        m = mode;
        if (mode == 1 && v >= 3) m = 2;
        send_vec(b[0], v[2:0], m, b == 1 && v == 4);
      end
  endtask

  // drop start, then hold off until every expected result is in
  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    bbsc_req_t r;
    int sent;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: fill everything, extremes, unused selectors, zeros
    send_pair(3);
    send_pair(0);
    r = '0;
    r.vector_select = 3'd7;
    r.last = 1'b1;
    send(r);
    r.vector_select = 3'd5;
    r.box_select = 1'b1;
    r.comp_x = 32'sh7fffffff;
    send(r);
    for (int v = 0; v < 5; v++) begin
      r = '0;
      r.vector_select = v[2:0];
      r.box_select = 1'b1;
      r.last = (v == 4);
      send(r);
    end
    wait_drain();
    // random: long quiet stretch, then mixed
    sent = 27;
    quiet = 1'b1;
    repeat (8) begin send_pair(1); sent += 10; end
    quiet = 1'b0;
    while (sent < 850) begin
      case ($urandom_range(9))
        0: begin
          send_vec(1'($urandom_range(1)), 3'($urandom_range(7)), $urandom_range(3),
                   1'($urandom_range(1)));
          sent++;
        end
        1: begin send_pair(0); sent += 10; end
        2: begin send_pair(3); sent += 10; end
        3: begin wait_drain(); send_pair(1); sent += 10; end
        default: begin send_pair(1); sent += 10; end
      endcase
    end
    wait_drain();
    repeat (500) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("box_box_sat_contact_test: done, clean");
    else
      $display("box_box_sat_contact_test: done, errors");
    $finish;
  end

endmodule

[files.f]
rtl/bbsc_pkg.sv
rtl/bbsc_dp.sv
rtl/bbsc_ctrl.sv
rtl/box_box_sat_contact.sv
tb/box_box_sat_contact_test.sv
